### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RRI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RRI_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRI_ASSERT(lbl, clk, rstn, prop, msg)
`define RRI_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

### rtl/rri_pkg.sv
// ----------------------------------------------------------------------------
// Ray/rectangle intersection package
// Register codes and the packed three-slot vector type.
// ----------------------------------------------------------------------------
package rri_pkg;

  localparam int unsigned SLOT_W    = 21;
  localparam int unsigned CFG_W     = 3 * SLOT_W;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE    = 2'd0,
    CFG_ALONG_U = 2'd1,
    CFG_ALONG_V = 2'd2,
    CFG_NORMAL  = 2'd3
  } cfg_reg_e;

  // Element 0 sits in the low bits and holds x.
  typedef logic [2:0][SLOT_W-1:0] vec_t;

endpackage

### rtl/ray_rectangle_intersect.sv
// ----------------------------------------------------------------------------
// Ray/rectangle intersection
// Tests one ray per cycle while the output is not stalled, against a configured rectangle in a fixed pipeline.
// ----------------------------------------------------------------------------
// The block accepts one ray request per clock while the pipeline advances and
// returns one result per request, in order, through three front-end stages
// for the dot products, one setup stage and one stage per quotient bit in the
// three divider lanes, and three back-end stages ending in the output
// register. The whole pipeline advances whenever the output register is empty
// or being taken, so the input is ready in that case.
// Write the rectangle registers only while no request is in flight.
module ray_rectangle_intersect #(
  parameter int unsigned COORD_BITS    = 21,
  parameter int unsigned DIR_FRAC_BITS = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rri_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rri_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COORD_BITS-1:0]        src_x_i,
  input  logic signed [COORD_BITS-1:0]        src_y_i,
  input  logic signed [COORD_BITS-1:0]        src_z_i,
  input  logic signed [DIR_FRAC_BITS+1:0]     dir_x_i,
  input  logic signed [DIR_FRAC_BITS+1:0]     dir_y_i,
  input  logic signed [DIR_FRAC_BITS+1:0]     dir_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o,
  output logic                                plane_reached_o,
  output logic signed [COORD_BITS-1:0]        point_x_o,
  output logic signed [COORD_BITS-1:0]        point_y_o,
  output logic signed [COORD_BITS-1:0]        point_z_o
);

  `include "assert_macros.svh"

  localparam int unsigned SW    = rri_pkg::SLOT_W;
  localparam int unsigned DB    = DIR_FRAC_BITS + 2;
  localparam int unsigned DIFFW = ((COORD_BITS > SW) ? COORD_BITS : SW) + 1;
  localparam int unsigned DENW  = SW + DB + 2;
  localparam int unsigned NUMW  = SW + DIFFW + 2;
  localparam int unsigned XW    = NUMW + DB;
  localparam int unsigned QW    = COORD_BITS + 3;

  rri_pkg::vec_t base_q, along_u_q, along_v_q, normal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      along_u_q <= '0;
      along_v_q <= '0;
      normal_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (rri_pkg::cfg_reg_e'(cfg_idx_i))
        rri_pkg::CFG_BASE:    base_q    <= cfg_data_i;
        rri_pkg::CFG_ALONG_U: along_u_q <= cfg_data_i;
        rri_pkg::CFG_ALONG_V: along_v_q <= cfg_data_i;
        rri_pkg::CFG_NORMAL:  normal_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic signed [COORD_BITS-1:0] src [3];
  logic signed [DB-1:0]         dir [3];
  assign src = '{src_x_i, src_y_i, src_z_i};
  assign dir = '{dir_x_i, dir_y_i, dir_z_i};

  logic                         f_valid, f_miss;
  logic [XW-1:0]                f_x [3];
  logic [DENW-1:0]              f_dmag;
  logic [2:0]                   f_dneg;
  logic signed [COORD_BITS-1:0] f_src [3];

  rri_front #(
    .COORD_BITS    (COORD_BITS),
    .DIR_FRAC_BITS (DIR_FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .src_i    (src),
    .dir_i    (dir),
    .base_i   (base_q),
    .normal_i (normal_q),
    .valid_o  (f_valid),
    .miss_o   (f_miss),
    .xmag_o   (f_x),
    .dmag_o   (f_dmag),
    .dneg_o   (f_dneg),
    .src_o    (f_src)
  );

  // Lane 0 also carries the miss flag alongside its sign and source.
  logic [2:0]                   d_valid;
  logic [QW-1:0]                d_quot [3];
  logic [2:0]                   d_ovf;
  logic [2:0]                   d_dneg;
  logic signed [COORD_BITS-1:0] d_src [3];
  logic                         d_miss;

  rri_divider #(
    .NW (XW), .DW (DENW), .QW (QW), .SW (COORD_BITS + 2)
  ) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (f_valid),
    .dividend_i (f_x[0]),
    .divisor_i  (f_dmag),
    .side_i     ({f_miss, f_dneg[0], f_src[0]}),
    .valid_o    (d_valid[0]),
    .quot_o     (d_quot[0]),
    .ovf_o      (d_ovf[0]),
    .side_o     ({d_miss, d_dneg[0], d_src[0]})
  );

  rri_divider #(
    .NW (XW), .DW (DENW), .QW (QW), .SW (COORD_BITS + 1)
  ) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (f_valid),
    .dividend_i (f_x[1]),
    .divisor_i  (f_dmag),
    .side_i     ({f_dneg[1], f_src[1]}),
    .valid_o    (d_valid[1]),
    .quot_o     (d_quot[1]),
    .ovf_o      (d_ovf[1]),
    .side_o     ({d_dneg[1], d_src[1]})
  );

  rri_divider #(
    .NW (XW), .DW (DENW), .QW (QW), .SW (COORD_BITS + 1)
  ) u_div_z (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (f_valid),
    .dividend_i (f_x[2]),
    .divisor_i  (f_dmag),
    .side_i     ({f_dneg[2], f_src[2]}),
    .valid_o    (d_valid[2]),
    .quot_o     (d_quot[2]),
    .ovf_o      (d_ovf[2]),
    .side_o     ({d_dneg[2], d_src[2]})
  );

  logic signed [COORD_BITS-1:0] point [3];

  rri_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (d_valid[0]),
    .miss_i    (d_miss),
    .quot_i    (d_quot),
    .ovf_i     (d_ovf),
    .dneg_i    (d_dneg),
    .src_i     (d_src),
    .base_i    (base_q),
    .along_u_i (along_u_q),
    .along_v_i (along_v_q),
    .valid_o   (out_valid_o),
    .hit_o     (hit_o),
    .reached_o (plane_reached_o),
    .point_o   (point)
  );

  assign point_x_o = point[0];
  assign point_y_o = point[1];
  assign point_z_o = point[2];

  `RRI_ASSERT(a_lanes_aligned, clk_i, rst_ni, d_valid[0] == d_valid[1] && d_valid[0] == d_valid[2], "divider lanes out of step")
  `RRI_ASSERT(a_hit_needs_plane, clk_i, rst_ni, out_valid_o && hit_o |-> plane_reached_o, "hit without plane")
  `RRI_ASSERT(a_miss_zero_point, clk_i, rst_ni, out_valid_o && !plane_reached_o |-> point_x_o == '0 && point_y_o == '0 && point_z_o == '0, "miss with nonzero point")
  `RRI_ASSERT_NORST(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule

### rtl/rri_front.sv
// ----------------------------------------------------------------------------
// Ray/rectangle front end
// Forms the plane dot products, flags misses and builds the dividends.
// ----------------------------------------------------------------------------
module rri_front #(
  parameter int unsigned COORD_BITS    = 21,
  parameter int unsigned DIR_FRAC_BITS = 14
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  logic signed [COORD_BITS-1:0]                  src_i [3],
  input  logic signed [DIR_FRAC_BITS+1:0]               dir_i [3],
  input  rri_pkg::vec_t                                 base_i,
  input  rri_pkg::vec_t                                 normal_i,
  output logic                                          valid_o,
  output logic                                          miss_o,
  output logic [rri_pkg::SLOT_W+((COORD_BITS > rri_pkg::SLOT_W) ? COORD_BITS :
                rri_pkg::SLOT_W)+3+DIR_FRAC_BITS+1:0]   xmag_o [3],
  output logic [rri_pkg::SLOT_W+DIR_FRAC_BITS+3:0]      dmag_o,
  output logic [2:0]                                    dneg_o,
  output logic signed [COORD_BITS-1:0]                  src_o [3]
);

  localparam int unsigned DB    = DIR_FRAC_BITS + 2;
  localparam int unsigned SW    = rri_pkg::SLOT_W;
  localparam int unsigned DIFFW = ((COORD_BITS > SW) ? COORD_BITS : SW) + 1;
  localparam int unsigned NPW   = SW + DB;
  localparam int unsigned DENW  = NPW + 2;
  localparam int unsigned NNW   = SW + DIFFW;
  localparam int unsigned NUMW  = NNW + 2;
  localparam int unsigned XW    = NUMW + DB;
  // Smallest raw |n.d| that is not treated as parallel: ceil(2^(2F) / 1e6).
  localparam longint unsigned NEAR =
    ((64'd1 << (2 * DIR_FRAC_BITS)) + 64'd999999) / 64'd1000000;

  logic [2:0]               valid_q;
  logic signed [NPW-1:0]    nd_q  [3];
  logic signed [NNW-1:0]    nn_q  [3];
  logic signed [COORD_BITS-1:0] s1_q [3];
  logic signed [DB-1:0]     d1_q  [3];
  logic signed [DENW-1:0]   den_q;
  logic signed [NUMW-1:0]   num_q;
  logic signed [COORD_BITS-1:0] s2_q [3];
  logic signed [DB-1:0]     d2_q  [3];
  logic                     miss_q;
  logic [XW-1:0]            x_q   [3];
  logic [DENW-1:0]          dmag_q;
  logic [2:0]               dneg_q;
  logic signed [COORD_BITS-1:0] s3_q [3];

  logic signed [DIFFW-1:0]  diff   [3];
  logic signed [NPW-1:0]    nd_d   [3];
  logic signed [NNW-1:0]    nn_d   [3];
  logic [DENW-1:0]          dmag_d;
  logic [NUMW-1:0]          nmag_d;
  logic [DB-1:0]            dirmag [3];
  logic [XW-1:0]            x_d    [3];
  logic                     miss_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = DIFFW'($signed(base_i[i])) - DIFFW'(src_i[i]);
      nd_d[i] = NPW'($signed(normal_i[i])) * NPW'(dir_i[i]);
      nn_d[i] = NNW'($signed(normal_i[i])) * NNW'(diff[i]);
    end
  end

  always_comb begin
    dmag_d = den_q[DENW-1] ? DENW'(-den_q) : DENW'(den_q);
    nmag_d = num_q[NUMW-1] ? NUMW'(-num_q) : NUMW'(num_q);
    // A ray that points away from the plane has t < 0 unless N is zero.
    miss_d = (dmag_d < DENW'(NEAR)) ||
             ((num_q != '0) && (num_q[NUMW-1] != den_q[DENW-1]));
    for (int i = 0; i < 3; i++) begin
      dirmag[i] = d2_q[i][DB-1] ? DB'(-d2_q[i]) : DB'(d2_q[i]);
      x_d[i]    = XW'(nmag_d) * XW'(dirmag[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nd_q  <= nd_d;
      nn_q  <= nn_d;
      s1_q  <= src_i;
      d1_q  <= dir_i;
      den_q <= DENW'(nd_q[0]) + DENW'(nd_q[1]) + DENW'(nd_q[2]);
      num_q <= NUMW'(nn_q[0]) + NUMW'(nn_q[1]) + NUMW'(nn_q[2]);
      s2_q  <= s1_q;
      d2_q  <= d1_q;
      miss_q <= miss_d;
      x_q    <= x_d;
      dmag_q <= dmag_d;
      dneg_q <= {d2_q[2][DB-1], d2_q[1][DB-1], d2_q[0][DB-1]};
      s3_q   <= s2_q;
    end
  end

  assign valid_o = valid_q[2];
  assign miss_o  = miss_q;
  assign xmag_o  = x_q;
  assign dmag_o  = dmag_q;
  assign dneg_o  = dneg_q;
  assign src_o   = s3_q;

endmodule

### rtl/rri_divider.sv
// ----------------------------------------------------------------------------
// Ray/rectangle pipelined divider
// Restoring division, one quotient bit per stage, with an overflow flag.
// ----------------------------------------------------------------------------
module rri_divider #(
  parameter int unsigned NW = 61,
  parameter int unsigned DW = 39,
  parameter int unsigned QW = 24,
  parameter int unsigned SW = 22
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic          ovf_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned CW = (NW > DW + QW) ? NW : DW + QW;
  localparam int unsigned RW = DW + 1;

  logic [QW:0]   valid_q;
  logic          ovf_q  [QW+1];
  logic [RW-1:0] rem_q  [QW+1];
  logic [QW-1:0] low_q  [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic [DW-1:0] dvs_q  [QW+1];
  logic [SW-1:0] side_q [QW+1];

  logic          ovf_d;
  logic [RW-1:0] rem0_d;

  // When the quotient fits in QW bits the top part is already below the divisor.
  always_comb begin
    ovf_d  = CW'(dividend_i) >= (CW'(divisor_i) << QW);
    rem0_d = RW'(CW'(dividend_i) >> QW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[QW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0]  <= ovf_d;
      rem_q[0]  <= rem0_d;
      low_q[0]  <= dividend_i[QW-1:0];
      quo_q[0]  <= '0;
      dvs_q[0]  <= divisor_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [RW-1:0] trial;
    logic          ge;
    logic [RW-1:0] rem_d;

    always_comb begin
      trial = {rem_q[k-1][DW-1:0], low_q[k-1][QW-1]};
      ge    = trial >= {1'b0, dvs_q[k-1]};
      rem_d = ge ? trial - {1'b0, dvs_q[k-1]} : trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ovf_q[k]  <= ovf_q[k-1];
        rem_q[k]  <= rem_d;
        low_q[k]  <= {low_q[k-1][QW-2:0], 1'b0};
        quo_q[k]  <= {quo_q[k-1][QW-2:0], ge};
        dvs_q[k]  <= dvs_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = valid_q[QW];
  assign quot_o  = quo_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign side_o  = side_q[QW];

endmodule

### rtl/rri_back.sv
// ----------------------------------------------------------------------------
// Ray/rectangle back end
// Builds the saturated point and runs both edge tests into the output register.
// ----------------------------------------------------------------------------
module rri_back #(
  parameter int unsigned COORD_BITS = 21
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic                         miss_i,
  input  logic [COORD_BITS+2:0]        quot_i [3],
  input  logic [2:0]                   ovf_i,
  input  logic [2:0]                   dneg_i,
  input  logic signed [COORD_BITS-1:0] src_i [3],
  input  rri_pkg::vec_t                base_i,
  input  rri_pkg::vec_t                along_u_i,
  input  rri_pkg::vec_t                along_v_i,
  output logic                         valid_o,
  output logic                         hit_o,
  output logic                         reached_o,
  output logic signed [COORD_BITS-1:0] point_o [3]
);

  localparam int unsigned SW    = rri_pkg::SLOT_W;
  localparam int unsigned QW    = COORD_BITS + 3;
  localparam int unsigned SUMW  = COORD_BITS + 5;
  localparam int unsigned DIFFW = ((COORD_BITS > SW) ? COORD_BITS : SW) + 1;
  localparam int unsigned EW    = SW + 1;
  localparam int unsigned PW    = DIFFW + EW;
  localparam int unsigned LPW   = 2 * EW;
  localparam int unsigned DOTW  = PW + 2;
  localparam int unsigned LENW  = LPW + 2;
  localparam logic [QW-1:0] CAP = QW'(1) << (COORD_BITS + 2);
  localparam logic signed [SUMW-1:0] P_MAX =
    {{(SUMW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [SUMW-1:0] P_MIN = ~P_MAX;

  logic [2:0]                   valid_q;
  logic                         miss1_q, miss2_q;
  logic signed [COORD_BITS-1:0] p1_q [3];
  logic signed [COORD_BITS-1:0] p2_q [3];
  logic signed [PW-1:0]         ru_q [3];
  logic signed [PW-1:0]         rv_q [3];
  logic signed [LPW-1:0]        uu_q [3];
  logic signed [LPW-1:0]        vv_q [3];
  logic                         hit_q, reached_q;
  logic signed [COORD_BITS-1:0] pt_q [3];

  logic [QW-1:0]                off  [3];
  logic signed [SUMW-1:0]       soff [3];
  logic signed [SUMW-1:0]       sum  [3];
  logic signed [COORD_BITS-1:0] p_d  [3];
  logic signed [DIFFW-1:0]      rel  [3];
  logic signed [EW-1:0]         eu   [3];
  logic signed [EW-1:0]         ev   [3];
  logic signed [DOTW-1:0]       dot_u, dot_v;
  logic signed [LENW-1:0]       len_u, len_v;
  logic                         in_u, in_v;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off[i]  = (ovf_i[i] || (quot_i[i] > CAP)) ? CAP : quot_i[i];
      soff[i] = dneg_i[i] ? -SUMW'(off[i]) : SUMW'(off[i]);
      sum[i]  = SUMW'(src_i[i]) + soff[i];
      if (sum[i] > P_MAX) begin
        p_d[i] = P_MAX[COORD_BITS-1:0];
      end else if (sum[i] < P_MIN) begin
        p_d[i] = P_MIN[COORD_BITS-1:0];
      end else begin
        p_d[i] = sum[i][COORD_BITS-1:0];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rel[i] = DIFFW'(p1_q[i]) - DIFFW'($signed(base_i[i]));
      eu[i]  = EW'($signed(along_u_i[i])) - EW'($signed(base_i[i]));
      ev[i]  = EW'($signed(along_v_i[i])) - EW'($signed(base_i[i]));
    end
  end

  always_comb begin
    dot_u = DOTW'(ru_q[0]) + DOTW'(ru_q[1]) + DOTW'(ru_q[2]);
    dot_v = DOTW'(rv_q[0]) + DOTW'(rv_q[1]) + DOTW'(rv_q[2]);
    len_u = LENW'(uu_q[0]) + LENW'(uu_q[1]) + LENW'(uu_q[2]);
    len_v = LENW'(vv_q[0]) + LENW'(vv_q[1]) + LENW'(vv_q[2]);
    // A zero-length edge never contains the point.
    in_u  = (len_u != '0) && (dot_u >= 0) && (dot_u <= DOTW'(len_u));
    in_v  = (len_v != '0) && (dot_v >= 0) && (dot_v <= DOTW'(len_v));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      miss1_q <= miss_i;
      p1_q    <= p_d;
      miss2_q <= miss1_q;
      p2_q    <= p1_q;
      for (int i = 0; i < 3; i++) begin
        ru_q[i] <= PW'(rel[i]) * PW'(eu[i]);
        rv_q[i] <= PW'(rel[i]) * PW'(ev[i]);
        uu_q[i] <= LPW'(eu[i]) * LPW'(eu[i]);
        vv_q[i] <= LPW'(ev[i]) * LPW'(ev[i]);
        pt_q[i] <= miss2_q ? '0 : p2_q[i];
      end
      hit_q     <= !miss2_q && in_u && in_v;
      reached_q <= !miss2_q;
    end
  end

  assign valid_o   = valid_q[2];
  assign hit_o     = hit_q;
  assign reached_o = reached_q;
  assign point_o   = pt_q;

endmodule

### tb/rri_checker.sv
// ----------------------------------------------------------------------------
// Ray/rectangle intersection checker
// Watches the register port and both request channels, predicts each result
// from its own copy of the rectangle registers and compares in order.
// ----------------------------------------------------------------------------
module rri_checker #(
  parameter int unsigned COORD_BITS    = 21,
  parameter int unsigned DIR_FRAC_BITS = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rri_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rri_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic signed [COORD_BITS-1:0]      src_x_i,
  input  logic signed [COORD_BITS-1:0]      src_y_i,
  input  logic signed [COORD_BITS-1:0]      src_z_i,
  input  logic signed [DIR_FRAC_BITS+1:0]   dir_x_i,
  input  logic signed [DIR_FRAC_BITS+1:0]   dir_y_i,
  input  logic signed [DIR_FRAC_BITS+1:0]   dir_z_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic                              hit_i,
  input  logic                              plane_reached_i,
  input  logic signed [COORD_BITS-1:0]      point_x_i,
  input  logic signed [COORD_BITS-1:0]      point_y_i,
  input  logic signed [COORD_BITS-1:0]      point_z_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                hits_o,
  output int                                reached_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PARALLEL_LIMIT =
    ((64'd1 << (2 * DIR_FRAC_BITS)) + 64'd999999) / 64'd1000000;
  localparam longint OFFSET_CAP = 64'd1 << (COORD_BITS + 2);
  localparam longint COORD_MAX  = (64'd1 << (COORD_BITS - 1)) - 1;

  typedef struct packed {
    logic                  hit;
    logic                  reached;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [COORD_BITS-1:0] pz;
  } ray_result_t;

  logic [rri_pkg::CFG_W-1:0] base_reg, along_u_reg, along_v_reg, normal_reg;
  ray_result_t               expected_results[$];

  function automatic longint slot(logic [rri_pkg::CFG_W-1:0] r, int i);
    return longint'($signed(r[i*rri_pkg::SLOT_W +: rri_pkg::SLOT_W]));
  endfunction

  function automatic longint magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit on_edge(longint rel[3], longint e[3]);
    longint dot, len2;
    dot  = rel[0] * e[0] + rel[1] * e[1] + rel[2] * e[2];
    len2 = e[0] * e[0] + e[1] * e[1] + e[2] * e[2];
    return len2 != 0 && dot >= 0 && dot <= len2;
  endfunction

  function automatic ray_result_t predict_intersection(longint s[3], longint d[3]);
    longint      b[3], n[3], p[3], rel[3], eu[3], ev[3];
    longint      den, num, off;
    logic [127:0] quo;
    ray_result_t r;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      b[i]  = slot(base_reg, i);
      n[i]  = slot(normal_reg, i);
      eu[i] = slot(along_u_reg, i) - b[i];
      ev[i] = slot(along_v_reg, i) - b[i];
    end
    den = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
    if (magnitude(den) < PARALLEL_LIMIT) return r;
    num = n[0] * (b[0] - s[0]) + n[1] * (b[1] - s[1]) + n[2] * (b[2] - s[2]);
    if (num != 0 && ((num < 0) != (den < 0))) return r;
    for (int i = 0; i < 3; i++) begin
      quo = (128'(magnitude(num)) * 128'(magnitude(d[i]))) / 128'(magnitude(den));
      off = (quo > 128'(OFFSET_CAP)) ? OFFSET_CAP : longint'(quo);
      p[i] = s[i] + ((d[i] < 0) ? -off : off);
      if (p[i] > COORD_MAX) p[i] = COORD_MAX;
      if (p[i] < -COORD_MAX - 1) p[i] = -COORD_MAX - 1;
      rel[i] = p[i] - b[i];
    end
    r.hit     = on_edge(rel, eu) && on_edge(rel, ev);
    r.reached = 1'b1;
    r.px      = p[0][COORD_BITS-1:0];
    r.py      = p[1][COORD_BITS-1:0];
    r.pz      = p[2][COORD_BITS-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: MISMATCH %s got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    hits_o       = 0;
    reached_o    = 0;
  end

  assign pending_o = expected_results.size();

  always @(posedge clk_i) begin
    longint      s[3], d[3];
    ray_result_t want;
    if (!rst_ni) begin
      base_reg    <= '0;
      along_u_reg <= '0;
      along_v_reg <= '0;
      normal_reg  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (rri_pkg::cfg_reg_e'(cfg_idx_i))
          rri_pkg::CFG_BASE:    base_reg    <= cfg_data_i;
          rri_pkg::CFG_ALONG_U: along_u_reg <= cfg_data_i;
          rri_pkg::CFG_ALONG_V: along_v_reg <= cfg_data_i;
          rri_pkg::CFG_NORMAL:  normal_reg  <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        s = '{longint'(src_x_i), longint'(src_y_i), longint'(src_z_i)};
        d = '{longint'(dir_x_i), longint'(dir_y_i), longint'(dir_z_i)};
        expected_results = {expected_results, predict_intersection(s, d)};
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("requests outstanding", 0, 1);
        end else begin
          want = expected_results.pop_front();
          hits_o    += want.hit;
          reached_o += want.reached;
          if (hit_i !== want.hit) report_mismatch("hit", hit_i, want.hit);
          if (plane_reached_i !== want.reached)
            report_mismatch("plane_reached", plane_reached_i, want.reached);
          if (point_x_i !== want.px)
            report_mismatch("point_x", point_x_i, $signed(want.px));
          if (point_y_i !== want.py)
            report_mismatch("point_y", point_y_i, $signed(want.py));
          if (point_z_i !== want.pz)
            report_mismatch("point_z", point_z_i, $signed(want.pz));
        end
      end
    end
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// Ray/rectangle intersection testbench
// Drives directed and random rays through several rectangle settings with
// random stalls on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB = 21;
  localparam int unsigned DF = 14;
  localparam int ONE_DIR     = 1 << DF;
  localparam int MM          = 256;
  localparam int IDLE_LIMIT  = 2000;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_we;
  logic [rri_pkg::CFG_IDX_W-1:0]    cfg_idx;
  logic [rri_pkg::CFG_W-1:0]        cfg_data;
  logic                             in_valid, in_ready, out_valid, out_ready;
  logic signed [CB-1:0]             src_x, src_y, src_z;
  logic signed [DF+1:0]             dir_x, dir_y, dir_z;
  logic                             hit, plane_reached;
  logic signed [CB-1:0]             point_x, point_y, point_z;
  int                               fail_count, pending, hits, reached;
  bit                               no_idle, hold_long;
  int                               idle_cycles, rays_sent;

  always #6 clk_i = ~clk_i;

  ray_rectangle_intersect #(.COORD_BITS(CB), .DIR_FRAC_BITS(DF)) DUT (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .src_x_i(src_x), .src_y_i(src_y), .src_z_i(src_z),
    .dir_x_i(dir_x), .dir_y_i(dir_y), .dir_z_i(dir_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .hit_o(hit), .plane_reached_o(plane_reached),
    .point_x_o(point_x), .point_y_o(point_y), .point_z_o(point_z)
  );

  rri_checker #(.COORD_BITS(CB), .DIR_FRAC_BITS(DF)) u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .src_x_i(src_x), .src_y_i(src_y), .src_z_i(src_z),
    .dir_x_i(dir_x), .dir_y_i(dir_y), .dir_z_i(dir_z),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .hit_i(hit), .plane_reached_i(plane_reached),
    .point_x_i(point_x), .point_y_i(point_y), .point_z_i(point_z),
    .fail_count_o(fail_count), .pending_o(pending),
    .hits_o(hits), .reached_o(reached)
  );

  function automatic logic [rri_pkg::CFG_W-1:0] pack3(int x, int y, int z);
    return {z[rri_pkg::SLOT_W-1:0], y[rri_pkg::SLOT_W-1:0], x[rri_pkg::SLOT_W-1:0]};
  endfunction

  // Register writes keep the enable high across back-to-back writes and drop
  // it once after the last one.
  task automatic load_rectangle(logic [rri_pkg::CFG_W-1:0] b, u, v, n);
    cfg_we <= 1'b1; cfg_idx <= rri_pkg::CFG_BASE; cfg_data <= b; @(posedge clk_i);
    cfg_idx <= rri_pkg::CFG_ALONG_U; cfg_data <= u; @(posedge clk_i);
    cfg_idx <= rri_pkg::CFG_ALONG_V; cfg_data <= v; @(posedge clk_i);
    cfg_idx <= rri_pkg::CFG_NORMAL;  cfg_data <= n; @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_ray(int sx, sy, sz, dx, dy, dz);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    src_x <= CB'(sx); src_y <= CB'(sy); src_z <= CB'(sz);
    dir_x <= (DF+2)'(dx); dir_y <= (DF+2)'(dy); dir_z <= (DF+2)'(dz);
    do @(posedge clk_i); while (!in_ready);
    rays_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // Axis-aligned rectangle of random size and place; plane_axis holds the normal.
  int plane_axis, corner[3], len_u, len_v;

  task automatic random_rectangle;
    int b[3], u[3], v[3], n[3];
    plane_axis = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) corner[i] = $signed($urandom_range(0, 400 * MM)) - 200 * MM;
    len_u = $urandom_range(1, 100 * MM);
    len_v = $urandom_range(1, 100 * MM);
    b = corner; u = corner; v = corner; n = '{0, 0, 0};
    u[(plane_axis + 1) % 3] += len_u;
    v[(plane_axis + 2) % 3] += len_v;
    n[plane_axis] = ($urandom_range(0, 1) != 0) ? ONE_DIR : -ONE_DIR;
    load_rectangle(pack3(b[0], b[1], b[2]), pack3(u[0], u[1], u[2]),
                   pack3(v[0], v[1], v[2]), pack3(n[0], n[1], n[2]));
  endtask

  task automatic random_ray;
    int s[3], d[3], h;
    if ($urandom_range(0, 3) == 0) begin
      // Noise: every bit of every field.
      send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      h = $urandom_range(0, 50 * MM);
      s = corner;
      s[(plane_axis + 1) % 3] += $signed($urandom_range(0, len_u + 40 * MM)) - 20 * MM;
      s[(plane_axis + 2) % 3] += $signed($urandom_range(0, len_v + 40 * MM)) - 20 * MM;
      if ($urandom_range(0, 1) != 0) h = -h;
      s[plane_axis] += h;
      for (int i = 0; i < 3; i++) d[i] = $signed($urandom_range(0, 2 * ONE_DIR)) - ONE_DIR;
      d[plane_axis] = (h > 0 ? -1 : 1) * $urandom_range(1, ONE_DIR);
      if ($urandom_range(0, 9) == 0) d[plane_axis] = -d[plane_axis];
      send_ray(s[0], s[1], s[2], d[0], d[1], d[2]);
    end
  endtask

  initial begin
    int items;
    rst_ni = 1'b1; cfg_we = 1'b0; cfg_idx = rri_pkg::CFG_BASE; cfg_data = '0;
    in_valid = 1'b0; src_x = '0; src_y = '0; src_z = '0;
    dir_x = '0; dir_y = '0; dir_z = '0;
    no_idle = 1'b0; hold_long = 1'b0; rays_sent = 0;
    // Reset falls after time zero so the asynchronous reset always sees the edge.
    #1 rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: the normal is zero, so everything is parallel.
    send_ray(1048575, -1048576, 0, 16384, -16384, 16384);
    send_ray(-1048576, 1048575, 7, -32768, 32767, 1);
    drain();

    // Floor rectangle 100 mm by 50 mm at z = 0, normal along +z.
    load_rectangle(pack3(0, 0, 0), pack3(100 * MM, 0, 0), pack3(0, 50 * MM, 0),
                   pack3(0, 0, ONE_DIR));
    send_ray(10 * MM, 10 * MM, 10 * MM, 0, 0, -ONE_DIR);        // hit
    send_ray(-10 * MM, 10 * MM, 10 * MM, 0, 0, -ONE_DIR);       // outside u
    send_ray(10 * MM, 60 * MM, 10 * MM, 0, 0, -ONE_DIR);        // outside v
    send_ray(10 * MM, 10 * MM, 10 * MM, 0, 0, ONE_DIR);         // plane behind
    send_ray(10 * MM, 10 * MM, 10 * MM, ONE_DIR, 0, 0);         // parallel
    send_ray(100, 100, 0, 0, 0, -ONE_DIR);                      // source on plane
    send_ray(100 * MM, 0, MM, 0, 0, -ONE_DIR);                  // far corner edge
    send_ray(0, 50 * MM, MM, 0, 0, -ONE_DIR);                   // other edge
    send_ray(1048575, 0, MM, 16384, 0, -1);                     // saturation
    send_ray(1048575, 1048575, 1048575, -16384, -16384, -16384);
    send_ray(-1048576, -1048576, -1048576, 16384, 16384, 16384);
    send_ray(0, 0, 1048575, 32767, -32768, -32768);
    send_ray(-1048576, 0, -MM, -32768, 32767, 32767);
    drain();

    // Degenerate edge: the u corner sits on the base.
    load_rectangle(pack3(0, 0, 0), pack3(0, 0, 0), pack3(0, 50 * MM, 0),
                   pack3(0, 0, ONE_DIR));
    send_ray(0, 10 * MM, 10 * MM, 0, 0, -ONE_DIR);
    send_ray(5 * MM, 10 * MM, 10 * MM, 0, 0, -ONE_DIR);
    drain();

    // Register extremes.
    load_rectangle({rri_pkg::CFG_W{1'b1}}, {rri_pkg::CFG_W{1'b0}},
                   {1'b0, {(rri_pkg::CFG_W-1){1'b1}}},
                   pack3(-1048576, -1048576, -1048576));
    send_ray(0, 0, 0, 1, 1, 1);
    send_ray(1048575, 1048575, 1048575, -1, -1, -1);
    send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    drain();
    load_rectangle(pack3(1048575, 1048575, 1048575), pack3(-1048576, 0, 0),
                   pack3(0, -1048576, 0), pack3(1048575, 1048575, 1048575));
    send_ray(0, 0, 0, 16384, 16384, 16384);
    send_ray(-1048576, -1048576, -1048576, 32767, 32767, 32767);
    drain();

    // Random phases, each with its own rectangle.
    for (int phase = 0; phase < 6; phase++) begin
      random_rectangle();
      items = 155;
      for (int k = 0; k < items; k++) begin
        no_idle = (k >= 40 && k < 70);
        if (phase == 1 && k == 80) hold_long = 1'b1;
        if (phase == 2 && k == 60) drain();
        random_ray();
      end
      no_idle = 1'b0;
      drain();
    end

    repeat (40) @(posedge clk_i);
    $display("Sent %0d rays over 6 random and 5 directed rectangle settings;",
             rays_sent);
    $display("%0d reached the plane and %0d hit the rectangle.", reached, hits);
    if (fail_count == 0 && pending == 0) begin
      $display("ray_rectangle_intersect test passed");
    end else begin
      $display("ray_rectangle_intersect test failed");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold that fills the pipeline.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (150) @(posedge clk_i);
        hold_long = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles", IDLE_LIMIT);
      $display("ray_rectangle_intersect test failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial idle_cycles = 0;

endmodule

### filelist.f
+incdir+rtl
rtl/rri_pkg.sv
rtl/rri_front.sv
rtl/rri_divider.sv
rtl/rri_back.sv
rtl/ray_rectangle_intersect.sv
tb/rri_checker.sv
tb/tb.sv
